/* src/ialu_pkg.sv */
// ---------------------------------------------------------------------------
// ialu_pkg: shared types and constants of the integer ALU
// Operation codes, masks and the item structures of the command and
// response channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ialu_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned MODE_W = 5;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_ADC     = 5'd0;
	localparam logic [MODE_W-1:0] MODE_ADD     = 5'd1;
	localparam logic [MODE_W-1:0] MODE_RSC     = 5'd2;
	localparam logic [MODE_W-1:0] MODE_SBC     = 5'd3;
	localparam logic [MODE_W-1:0] MODE_RSB     = 5'd4;
	localparam logic [MODE_W-1:0] MODE_SUB     = 5'd5;
	localparam logic [MODE_W-1:0] MODE_SXTB    = 5'd6;
	localparam logic [MODE_W-1:0] MODE_SXTAB   = 5'd7;
	localparam logic [MODE_W-1:0] MODE_SXTB16  = 5'd8;
	localparam logic [MODE_W-1:0] MODE_SXTAB16 = 5'd9;
	localparam logic [MODE_W-1:0] MODE_SXTH    = 5'd10;
	localparam logic [MODE_W-1:0] MODE_SXTAH   = 5'd11;
	localparam logic [MODE_W-1:0] MODE_UXTB    = 5'd12;
	localparam logic [MODE_W-1:0] MODE_UXTAB   = 5'd13;
	localparam logic [MODE_W-1:0] MODE_UXTB16  = 5'd14;
	localparam logic [MODE_W-1:0] MODE_UXTAB16 = 5'd15;
	localparam logic [MODE_W-1:0] MODE_UXTH    = 5'd16;
	localparam logic [MODE_W-1:0] MODE_UXTAH   = 5'd17;
	localparam logic [MODE_W-1:0] MODE_SEL     = 5'd18;

	// extend masks
	localparam logic [WORD_W-1:0] MASK_BYTE   = 32'h0000_00FF;
	localparam logic [WORD_W-1:0] MASK_HALF   = 32'h0000_FFFF;
	localparam logic [WORD_W-1:0] MASK_BYTE16 = 32'h00FF_00FF;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [WORD_W-1:0] first_operand;
		logic [WORD_W-1:0] second_operand;
		logic [1:0]        rotate;
		logic              carry_flag;
		logic [3:0]        ge_flags;
		logic              set_flags;
		logic              dest_is_pc;
	} cmd_t;

	typedef struct packed {
		logic [WORD_W-1:0] result;
		logic              neg_flag;
		logic              zero_flag;
		logic              carry_out;
		logic              overflow_out;
		logic              flags_written;
		logic              restore_status;
	} rsp_t;

endpackage

/* src/ialu_if.sv */
// ---------------------------------------------------------------------------
// ialu_if: command and response channels of the integer ALU
// Valid/ready channels; an item moves when valid and ready are both high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ialu_cmd_if import ialu_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ialu_rsp_if import ialu_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* src/ialu_core.sv */
// ---------------------------------------------------------------------------
// ialu_core: datapath of the integer ALU
// One pass of add/subtract with flags, rotate and extend with optional
// accumulate, and byte select, for one registered item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ialu_core import ialu_pkg::*; (
	input  cmd_t cmd,
	output rsp_t rsp
);

	logic              arith;
	logic [WORD_W-1:0] add_a;
	logic [WORD_W-1:0] add_b;
	logic              add_cin;
	logic [WORD_W:0]   sum;
	logic [WORD_W-1:0] sum_lo;
	logic              sum_v;

	logic [WORD_W-1:0] rm;
	logic [WORD_W-1:0] ext;
	logic              acc;
	logic              dual;
	logic [WORD_W-1:0] acc_val;
	logic [16:0]       ext_lo;
	logic [15:0]       ext_hi;
	logic [WORD_W-1:0] sel_val;
	logic [WORD_W-1:0] res;
	logic              fw;

	// pick adder operands: reversed forms swap and invert the first operand
	always_comb begin
		arith   = 1'b1;
		add_a   = cmd.first_operand;
		add_b   = ~cmd.second_operand;
		add_cin = 1'b1;
		case (cmd.mode)
			MODE_ADC: begin
				add_b   = cmd.second_operand;
				add_cin = cmd.carry_flag;
			end
			MODE_ADD: begin
				add_b   = cmd.second_operand;
				add_cin = 1'b0;
			end
			MODE_RSC: begin
				add_a   = cmd.second_operand;
				add_b   = ~cmd.first_operand;
				add_cin = cmd.carry_flag;
			end
			MODE_SBC: add_cin = cmd.carry_flag;
			MODE_RSB: begin
				add_a = cmd.second_operand;
				add_b = ~cmd.first_operand;
			end
			MODE_SUB: add_cin = 1'b1;
			default:  arith = 1'b0;
		endcase
	end

	assign sum    = {1'b0, add_a} + {1'b0, add_b} + {{WORD_W{1'b0}}, add_cin};
	assign sum_lo = sum[WORD_W-1:0];
	assign sum_v  = ~(add_a[WORD_W-1] ^ add_b[WORD_W-1]) & (add_a[WORD_W-1] ^ sum_lo[WORD_W-1]);

	// rotate right by whole bytes
	always_comb begin
		case (cmd.rotate)
			2'd1:    rm = {cmd.second_operand[7:0],  cmd.second_operand[31:8]};
			2'd2:    rm = {cmd.second_operand[15:0], cmd.second_operand[31:16]};
			2'd3:    rm = {cmd.second_operand[23:0], cmd.second_operand[31:24]};
			default: rm = cmd.second_operand;
		endcase
	end

	// extend the rotated value; mark accumulate and dual-halfword forms
	always_comb begin
		ext  = '0;
		acc  = 1'b0;
		dual = 1'b0;
		case (cmd.mode)
			MODE_SXTB, MODE_SXTAB: begin
				ext = {{24{rm[7]}}, rm[7:0]};
				acc = (cmd.mode == MODE_SXTAB);
			end
			MODE_SXTB16, MODE_SXTAB16: begin
				ext  = {{8{rm[23]}}, rm[23:16], {8{rm[7]}}, rm[7:0]};
				acc  = (cmd.mode == MODE_SXTAB16);
				dual = 1'b1;
			end
			MODE_SXTH, MODE_SXTAH: begin
				ext = {{16{rm[15]}}, rm[15:0]};
				acc = (cmd.mode == MODE_SXTAH);
			end
			MODE_UXTB, MODE_UXTAB: begin
				ext = rm & MASK_BYTE;
				acc = (cmd.mode == MODE_UXTAB);
			end
			MODE_UXTB16, MODE_UXTAB16: begin
				ext  = rm & MASK_BYTE16;
				acc  = (cmd.mode == MODE_UXTAB16);
				dual = 1'b1;
			end
			MODE_UXTH, MODE_UXTAH: begin
				ext = rm & MASK_HALF;
				acc = (cmd.mode == MODE_UXTAH);
			end
			default: ext = '0;
		endcase
	end

	// accumulate as two halves; break the carry for dual-halfword forms
	assign acc_val = acc ? cmd.first_operand : '0;
	assign ext_lo  = {1'b0, acc_val[15:0]} + {1'b0, ext[15:0]};
	assign ext_hi  = acc_val[31:16] + ext[31:16] + {15'b0, ext_lo[16] & ~dual};

	// byte select under the greater-or-equal flags
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sel_val[8*i +: 8] = cmd.ge_flags[i] ? cmd.first_operand[8*i +: 8]
			                                    : cmd.second_operand[8*i +: 8];
		end
	end

	// choose the result
	always_comb begin
		if (arith) begin
			res = sum_lo;
		end else if (cmd.mode == MODE_SEL) begin
			res = sel_val;
		end else if (cmd.mode >= MODE_SXTB && cmd.mode <= MODE_UXTAH) begin
			res = {ext_hi, ext_lo[15:0]};
		end else begin
			res = '0;
		end
	end

	assign fw = arith & cmd.set_flags & ~cmd.dest_is_pc;

	assign rsp.result         = res;
	assign rsp.neg_flag       = fw & res[WORD_W-1];
	assign rsp.zero_flag      = fw & (res == '0);
	assign rsp.carry_out      = fw & sum[WORD_W];
	assign rsp.overflow_out   = fw & sum_v;
	assign rsp.flags_written  = fw;
	assign rsp.restore_status = arith & cmd.set_flags & cmd.dest_is_pc;

endmodule

/* src/integer_alu_add_sub_extend_select.sv */
// ---------------------------------------------------------------------------
// integer_alu_add_sub_extend_select: 32-bit integer ALU
// Input register, one pass of ALU logic, result register.
// ---------------------------------------------------------------------------
// Takes one item per clock unless the response side stalls. Once accepted,
// the command lands in an input register, the ALU logic works on
// it, and the result register drives the response channel. Both registers
// advance whenever they are empty or the stage after them moves, so ready
// on the command side follows response ready through the two stages and
// the block streams back to back with no bubbles. Flags are zero unless
// flags_written is set; undefined operation codes return all zeros.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_alu_add_sub_extend_select import ialu_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	ialu_cmd_if.sink         cmd,
	ialu_rsp_if.source       rsp
);

	logic valid_s1;
	cmd_t data_s1;
	logic valid_s2;
	rsp_t data_s2;
	rsp_t core_rsp;
	logic adv_s1;
	logic adv_s2;

	// advance each stage when it is empty or its item moves on
	assign adv_s2    = ~valid_s2 | rsp.ready;
	assign adv_s1    = ~valid_s1 | adv_s2;
	assign cmd.ready = adv_s1;

	// hold valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= cmd.valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	// capture payloads
	always_ff @(posedge clk) begin
		if (adv_s1) data_s1 <= cmd.data;
		if (adv_s2) data_s2 <= core_rsp;
	end

	ialu_core u_core (
		.cmd (data_s1),
		.rsp (core_rsp)
	);

	assign rsp.valid = valid_s2;
	assign rsp.data  = data_s2;

	// a stalled input item stays put
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s2 |=> valid_s1 && $stable(data_s1))
		else $error("input stage item changed while stalled");

	// flags only appear with flags_written
	a_flags_gated: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !data_s2.flags_written |-> !data_s2.neg_flag && !data_s2.zero_flag
			&& !data_s2.carry_out && !data_s2.overflow_out)
		else $error("flags set without flags_written");

	// flag write and status restore exclude each other
	a_fw_rs: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(data_s2.flags_written && data_s2.restore_status))
		else $error("flags_written and restore_status both set");

	// negative flag tracks the result sign
	a_neg: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && data_s2.flags_written |-> data_s2.neg_flag == data_s2.result[31])
		else $error("neg_flag disagrees with result");

endmodule

/* bench/alu_result_monitor.sv */
// ---------------------------------------------------------------------------
// alu_result_monitor: predicts and checks every integer ALU result
// Watches both channels of the block. Each accepted command is turned into
// its expected response and queued. Each accepted response is compared,
// field by field, with the oldest queued one. Failures are counted for the
// top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module alu_result_monitor import ialu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	ialu_cmd_if  cmd,
	ialu_rsp_if  rsp,
	output int   fail_count,
	output int   pending
);

	rsp_t expected_results[$];

	// Compute the response of one command.
	function automatic rsp_t alu_outcome(cmd_t c);
		logic [2*WORD_W-1:0] doubled;
		logic [WORD_W-1:0]   rm;
		logic [WORD_W-1:0]   rn;
		logic [WORD_W-1:0]   op2;
		logic [WORD_W-1:0]   addend_a;
		logic [WORD_W-1:0]   addend_b;
		logic [WORD_W-1:0]   res;
		logic [WORD_W:0]     sum;
		logic [15:0]         lo;
		logic [15:0]         hi;
		logic                cin;
		logic                arith;
		logic                cy;
		logic                ov;
		logic                fw;
		logic                rs;
		rsp_t                out;

		rn       = c.first_operand;
		op2      = c.second_operand;
		doubled  = {op2, op2} >> (8 * c.rotate);
		rm       = doubled[WORD_W-1:0];
		addend_a = '0;
		addend_b = '0;
		cin      = 1'b0;
		arith    = 1'b0;
		res      = '0;
		cy       = 1'b0;
		ov       = 1'b0;

		case (c.mode)
			MODE_ADC: begin
				addend_a = rn; addend_b = op2; cin = c.carry_flag; arith = 1'b1;
			end
			MODE_ADD: begin
				addend_a = rn; addend_b = op2; cin = 1'b0; arith = 1'b1;
			end
			MODE_RSC: begin
				addend_a = op2; addend_b = ~rn; cin = c.carry_flag; arith = 1'b1;
			end
			MODE_SBC: begin
				addend_a = rn; addend_b = ~op2; cin = c.carry_flag; arith = 1'b1;
			end
			MODE_RSB: begin
				addend_a = op2; addend_b = ~rn; cin = 1'b1; arith = 1'b1;
			end
			MODE_SUB: begin
				addend_a = rn; addend_b = ~op2; cin = 1'b1; arith = 1'b1;
			end
			MODE_SXTB:   res = {{24{rm[7]}}, rm[7:0]};
			MODE_SXTAB:  res = rn + {{24{rm[7]}}, rm[7:0]};
			MODE_SXTB16: res = {{8{rm[23]}}, rm[23:16], {8{rm[7]}}, rm[7:0]};
			MODE_SXTAB16: begin
				lo  = rn[15:0] + {{8{rm[7]}}, rm[7:0]};
				hi  = rn[31:16] + {{8{rm[23]}}, rm[23:16]};
				res = {hi, lo};
			end
			MODE_SXTH:   res = {{16{rm[15]}}, rm[15:0]};
			MODE_SXTAH:  res = rn + {{16{rm[15]}}, rm[15:0]};
			MODE_UXTB:   res = rm & MASK_BYTE;
			MODE_UXTAB:  res = rn + (rm & MASK_BYTE);
			MODE_UXTB16: res = rm & MASK_BYTE16;
			MODE_UXTAB16: begin
				lo  = rn[15:0] + {8'h00, rm[7:0]};
				hi  = rn[31:16] + {8'h00, rm[23:16]};
				res = {hi, lo};
			end
			MODE_UXTH:   res = rm & MASK_HALF;
			MODE_UXTAH:  res = rn + (rm & MASK_HALF);
			MODE_SEL: begin
				for (int i = 0; i < 4; i++) begin
					res[8*i +: 8] = c.ge_flags[i] ? rn[8*i +: 8] : op2[8*i +: 8];
				end
			end
			default: res = '0;
		endcase

		// Run the shared adder; subtraction arrives here with an inverted operand.
		if (arith) begin
			sum = {1'b0, addend_a} + {1'b0, addend_b} + {{WORD_W{1'b0}}, cin};
			res = sum[WORD_W-1:0];
			cy  = sum[WORD_W];
			ov  = ~(addend_a[31] ^ addend_b[31]) & (addend_a[31] ^ res[31]);
		end

		fw = arith & c.set_flags & ~c.dest_is_pc;
		rs = arith & c.set_flags & c.dest_is_pc;

		out.result         = res;
		out.neg_flag       = fw & res[31];
		out.zero_flag      = fw & (res == '0);
		out.carry_out      = fw & cy;
		out.overflow_out   = fw & ov;
		out.flags_written  = fw;
		out.restore_status = rs;
		return out;
	endfunction

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	// Check each response against the oldest expectation, then queue new ones.
	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result: %p", rsp.data);
					fail_count = fail_count + 1;
				end else begin
					exp_rsp = expected_results.pop_front();
					if (rsp.data !== exp_rsp) begin
						if (fail_count < 10) begin
							$display("result mismatch at %0t", $realtime);
							$display("  expected result=%h N=%b Z=%b C=%b V=%b fw=%b rs=%b",
								exp_rsp.result, exp_rsp.neg_flag, exp_rsp.zero_flag,
								exp_rsp.carry_out, exp_rsp.overflow_out,
								exp_rsp.flags_written, exp_rsp.restore_status);
							$display("  actual   result=%h N=%b Z=%b C=%b V=%b fw=%b rs=%b",
								rsp.data.result, rsp.data.neg_flag, rsp.data.zero_flag,
								rsp.data.carry_out, rsp.data.overflow_out,
								rsp.data.flags_written, rsp.data.restore_status);
						end
						fail_count = fail_count + 1;
					end
				end
			end
			if (cmd.valid && cmd.ready)
				expected_results.push_back(alu_outcome(cmd.data));
			pending <= expected_results.size();
		end
	end

endmodule

/* bench/testbench.sv */
// ---------------------------------------------------------------------------
// testbench: stimulus and verdict for the integer ALU
// Sends a directed set of corner operations and then random operations
// with random gaps on both channels, a long response stall and a full
// drain. The result monitor does all prediction and checking.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import ialu_pkg::*;

	localparam int RANDOM_ITEMS  = 1350;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int LONG_HOLD     = 150;
	localparam int HOLD_AT_ITEM  = 500;
	localparam int DRAIN_AT_ITEM = 700;
	localparam logic [MODE_W-1:0] MODE_UNDEF_LOW  = MODE_SEL + 5'd1;
	localparam logic [MODE_W-1:0] MODE_UNDEF_HIGH = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	int   cycles = 0;
	bit   send_idle = 1'b0;

	ialu_cmd_if cmd_ch();
	ialu_rsp_if rsp_ch();

	integer_alu_add_sub_extend_select DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	alu_result_monitor result_monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic cmd_t make_cmd(logic [MODE_W-1:0] mode, logic [WORD_W-1:0] rn,
			logic [WORD_W-1:0] op2, logic [1:0] rot, logic cf, logic [3:0] ge,
			logic s, logic pc);
		cmd_t c;
		c.mode           = mode;
		c.first_operand  = rn;
		c.second_operand = op2;
		c.rotate         = rot;
		c.carry_flag     = cf;
		c.ge_flags       = ge;
		c.set_flags      = s;
		c.dest_is_pc     = pc;
		return c;
	endfunction

	// Favor the values where carries, overflows and sign bits turn over.
	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return $urandom_range(0, 255);
			5: return 32'hFFFF_FF80 | $urandom_range(0, 127);
			default: return $urandom;
		endcase
	endfunction

	function automatic cmd_t random_cmd();
		logic [MODE_W-1:0] mode;
		logic [WORD_W-1:0] rn;
		logic [WORD_W-1:0] op2;
		if ($urandom_range(0, 9) == 0)
			mode = MODE_W'($urandom_range(MODE_UNDEF_LOW, MODE_UNDEF_HIGH));
		else
			mode = MODE_W'($urandom_range(MODE_ADC, MODE_SEL));
		rn  = pick_word();
		op2 = ($urandom_range(0, 7) == 0) ? rn : pick_word();
		return make_cmd(mode, rn, op2, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
			4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endfunction

	// Offer one item, after a random gap when idling is on, and hold it until it is taken.
	task automatic send_item(cmd_t c);
		int gap;
		gap = send_idle ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			@(negedge clk);
			cmd_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= c;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	// Drop valid and wait until every expected result has come back.
	task automatic drain();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// Response side: random stalls, stretches without them, one long hold.
	initial begin
		int gap;
		int taken;
		bit rsp_idle;
		taken    = 0;
		rsp_idle = 1'b0;
		rsp_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			if (taken % 64 == 0)
				rsp_idle = ($urandom_range(0, 3) != 0);
			gap = rsp_idle ? $urandom_range(0, 8) : 0;
			if (taken == HOLD_AT_ITEM)
				gap = LONG_HOLD;
			if (gap > 0) begin
				@(negedge clk);
				rsp_ch.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			taken++;
		end
	end

	// Command side and verdict
	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.data  = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// corner cases of the add/subtract forms
		send_item(make_cmd(MODE_ADC, '1, '0, 2'd0, 1'b1, 4'h0, 1'b1, 1'b0));
		send_item(make_cmd(MODE_ADD, 32'h7FFF_FFFF, 32'h1, 2'd3, 1'b1, 4'hF, 1'b1, 1'b0));
		send_item(make_cmd(MODE_ADD, '1, 32'h1, 2'd0, 1'b0, 4'h0, 1'b1, 1'b1));
		send_item(make_cmd(MODE_RSC, 32'h1, '0, 2'd1, 1'b0, 4'h0, 1'b1, 1'b0));
		send_item(make_cmd(MODE_SBC, 32'h8000_0000, 32'h1, 2'd0, 1'b1, 4'h0, 1'b1, 1'b0));
		send_item(make_cmd(MODE_RSB, '0, '0, 2'd0, 1'b0, 4'h0, 1'b1, 1'b0));
		send_item(make_cmd(MODE_SUB, '0, '1, 2'd2, 1'b1, 4'h0, 1'b0, 1'b0));
		send_item(make_cmd(MODE_SUB, 32'h8000_0000, 32'h8000_0000, 2'd0, 1'b0, 4'h0,
			1'b1, 1'b1));

		// extend forms with each rotate; set bit and destination are ignored
		send_item(make_cmd(MODE_SXTB, '0, 32'h0000_0080, 2'd0, 1'b0, 4'h0, 1'b1, 1'b0));
		send_item(make_cmd(MODE_SXTAB, '1, 32'h7F00_0000, 2'd3, 1'b0, 4'h0, 1'b0, 1'b0));
		send_item(make_cmd(MODE_SXTB16, '0, 32'h80FF_7F00, 2'd1, 1'b1, 4'h0, 1'b0, 1'b0));
		send_item(make_cmd(MODE_SXTAB16, 32'h7FFF_8000, '1, 2'd2, 1'b0, 4'h0, 1'b0, 1'b0));
		send_item(make_cmd(MODE_SXTH, '0, 32'h0000_8000, 2'd0, 1'b0, 4'h0, 1'b1, 1'b1));
		send_item(make_cmd(MODE_SXTAH, '0, 32'h8000_0000, 2'd2, 1'b0, 4'h0, 1'b0, 1'b0));
		send_item(make_cmd(MODE_UXTB, '0, '1, 2'd3, 1'b0, 4'h0, 1'b1, 1'b0));
		send_item(make_cmd(MODE_UXTAB, '1, 32'h0000_00FF, 2'd0, 1'b0, 4'h0, 1'b0, 1'b0));
		send_item(make_cmd(MODE_UXTB16, '0, 32'hA5A5_A5A5, 2'd1, 1'b0, 4'h0, 1'b0, 1'b0));
		send_item(make_cmd(MODE_UXTAB16, '1, '1, 2'd0, 1'b0, 4'h0, 1'b0, 1'b0));
		send_item(make_cmd(MODE_UXTH, '0, 32'h1234_5678, 2'd2, 1'b0, 4'h0, 1'b0, 1'b0));
		send_item(make_cmd(MODE_UXTAH, 32'hFFFF_0001, '1, 2'd1, 1'b0, 4'h0, 1'b0, 1'b0));

		// byte select both ways, then undefined codes
		send_item(make_cmd(MODE_SEL, '1, '0, 2'd3, 1'b1, 4'b0101, 1'b1, 1'b1));
		send_item(make_cmd(MODE_SEL, '1, '0, 2'd0, 1'b0, 4'b1010, 1'b0, 1'b0));
		send_item(make_cmd(MODE_UNDEF_LOW, '1, '1, 2'd3, 1'b1, 4'hF, 1'b1, 1'b0));
		send_item(make_cmd(MODE_UNDEF_HIGH, '1, '1, 2'd3, 1'b1, 4'hF, 1'b1, 1'b1));
		drain();

		// random operations, idling switched per stretch
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0)
				send_idle = ($urandom_range(0, 3) != 0);
			if (n == DRAIN_AT_ITEM)
				drain();
			send_item(random_cmd());
		end
		drain();
		repeat (4) @(posedge clk);

		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
